>>> src/ntsb_pkg.sv
// Package for the newest-first time-sorted buffer.
// Holds field widths, operation codes and the cell control and flag structs.
// No dependencies.
`default_nettype none

package ntsb_pkg;

  localparam int TIME_W  = 63;
  localparam int CAP_W   = 7;
  localparam int SLOT_W  = 6;
  localparam int CNT_O_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_READ   = 1'b1
  } func_t;

  // Per-cell control from the top level for one request.
  typedef struct packed {
    logic ins;       // shift-insert request in progress
    logic app_here;  // append lands in this cell
    logic below_n;   // cell holds a stored entry
    logic last;      // cell holds the oldest stored entry
  } cell_ctl_t;

  // Per-cell compare results back to the top level.
  typedef struct packed {
    logic lt;        // new time is older than this stored entry
    logic le_last;   // oldest entry and new time is at or below it
  } cell_flag_t;

endpackage

`default_nettype wire

>>> src/newest_k_time_sorted_buffer_top.sv
// Latency: a request accepted at one edge has its result in the output register
// after that edge. Throughput: one request per cycle unless out_ready stalls,
// set by the row of cells that compares the new time in every cell and shifts
// or inserts in that cycle. Reset: stored count goes to zero and capacity to
// 64; the entry store is not cleared, and entries at or above the count are
// never read back. Depends on ntsb_pkg and ntsb_cell.
`default_nettype none

module newest_k_time_sorted_buffer_top #(
  parameter int DEPTH     = 64,
  parameter int TAG_WIDTH = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_wr_en,
  input  wire  [ntsb_pkg::CAP_W-1:0]    cfg_wr_data,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire                           in_func,
  input  wire  [ntsb_pkg::TIME_W-1:0]   in_timestamp,
  input  wire  [TAG_WIDTH-1:0]          in_row_tag,
  input  wire  [ntsb_pkg::SLOT_W-1:0]   in_read_index,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic                          out_accepted,
  output logic [ntsb_pkg::SLOT_W-1:0]   out_slot,
  output logic                          out_dropped,
  output logic [TAG_WIDTH-1:0]          out_dropped_tag,
  output logic                          out_full_res,
  output logic [ntsb_pkg::CNT_O_W-1:0]  out_count,
  output logic                          out_read_valid,
  output logic [ntsb_pkg::TIME_W-1:0]   out_read_time,
  output logic [TAG_WIDTH-1:0]          out_read_tag
);
  import ntsb_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WIDE  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Capacity clamped to one..DEPTH.
  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CAP_W-1:0] raw);
    logic [WIDE-1:0] w;
    if (raw == '0) begin
      w = WIDE'(1);
    end else if (WIDE'(raw) > WIDE'(DEPTH)) begin
      w = WIDE'(DEPTH);
    end else begin
      w = WIDE'(raw);
    end
    return CNT_W'(w);
  endfunction

  logic [CAP_W-1:0]  capacity_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  eff_cap, cfg_eff, cnt_after;

  logic              out_valid_r;
  logic              accepted_r, dropped_r, full_r, rvalid_r;
  logic [SLOT_W-1:0] slot_r;
  logic [TAG_WIDTH-1:0] dtag_r, rtag_r;
  logic [TIME_W-1:0] rtime_r;
  logic [CNT_O_W-1:0] cnt_o_r;

  cell_ctl_t         ctl   [DEPTH];
  cell_flag_t        flags [DEPTH];
  logic [TIME_W-1:0] time_q [DEPTH];
  logic [TAG_WIDTH-1:0] tag_q [DEPTH];
  logic [DEPTH-1:0]  lt_v, le_v, bnd_v;

  logic              fire, is_ins, app, room, ins_path, rd_hit;
  logic [IDX_W-1:0]  pos;
  logic [TAG_WIDTH-1:0] last_tag, rd_tag;
  logic [TIME_W-1:0] rd_time;

  assign fire     = in_valid && in_ready;
  assign is_ins   = fire && (in_func == FUNC_INSERT);
  assign app      = |le_v;
  assign room     = WIDE'(count_r) < WIDE'(eff_cap);
  assign ins_path = is_ins && !app;
  assign eff_cap  = clamp_cap(capacity_r);
  assign cfg_eff  = clamp_cap(cfg_wr_data);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      assign ctl[gi].ins      = ins_path;
      assign ctl[gi].below_n  = WIDE'(gi) < WIDE'(count_r);
      assign ctl[gi].last     = (WIDE'(gi + 1) == WIDE'(count_r));
      assign ctl[gi].app_here = is_ins && app && room && (WIDE'(gi) == WIDE'(count_r));
      assign lt_v[gi] = flags[gi].lt;
      assign le_v[gi] = flags[gi].le_last;

      if (gi == 0) begin : g_head
        assign bnd_v[gi] = !lt_v[gi];
        ntsb_cell #(.TAG_W(TAG_WIDTH)) u_cell (
          .clk       (clk),
          .ctl       (ctl[gi]),
          .new_time  (in_timestamp),
          .new_tag   (in_row_tag),
          .prev_time (in_timestamp),
          .prev_tag  (in_row_tag),
          .prev_lt   (1'b1),
          .time_q    (time_q[gi]),
          .tag_q     (tag_q[gi]),
          .flags     (flags[gi])
        );
      end else begin : g_body
        assign bnd_v[gi] = !lt_v[gi] && lt_v[gi-1];
        ntsb_cell #(.TAG_W(TAG_WIDTH)) u_cell (
          .clk       (clk),
          .ctl       (ctl[gi]),
          .new_time  (in_timestamp),
          .new_tag   (in_row_tag),
          .prev_time (time_q[gi-1]),
          .prev_tag  (tag_q[gi-1]),
          .prev_lt   (lt_v[gi-1]),
          .time_q    (time_q[gi]),
          .tag_q     (tag_q[gi]),
          .flags     (flags[gi])
        );
      end
    end
  endgenerate

  // Insert position, oldest tag and read data are picked out of the row.
  always_comb begin
    pos      = '0;
    last_tag = '0;
    rd_time  = '0;
    rd_tag   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (bnd_v[i]) begin
        pos = pos | IDX_W'(i);
      end
      if (ctl[i].last) begin
        last_tag = last_tag | tag_q[i];
      end
      if (WIDE'(in_read_index) == WIDE'(i)) begin
        rd_time = rd_time | time_q[i];
        rd_tag  = rd_tag | tag_q[i];
      end
    end
  end

  assign rd_hit    = WIDE'(in_read_index) < WIDE'(count_r);
  assign cnt_after = (is_ins && room) ? CNT_W'(count_r + 1'b1) : count_r;

  always_comb begin
    count_nxt = count_r;
    if (cfg_wr_en) begin
      count_nxt = (count_r > cfg_eff) ? cfg_eff : count_r;
    end else if (fire) begin
      count_nxt = cnt_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      accepted_r <= is_ins && (!app || room);
      if (is_ins && app && room) begin
        slot_r <= SLOT_W'(count_r);
      end else if (ins_path) begin
        slot_r <= SLOT_W'(pos);
      end else begin
        slot_r <= '0;
      end
      dropped_r <= ins_path && !room;
      dtag_r    <= (ins_path && !room) ? last_tag : '0;
      full_r    <= cnt_after >= eff_cap;
      cnt_o_r   <= CNT_O_W'(cnt_after);
      rvalid_r  <= !is_ins && rd_hit;
      rtime_r   <= (!is_ins && rd_hit) ? rd_time : '0;
      rtag_r    <= (!is_ins && rd_hit) ? rd_tag : '0;
    end
  end

  assign in_ready        = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_accepted    = accepted_r;
  assign out_slot        = slot_r;
  assign out_dropped     = dropped_r;
  assign out_dropped_tag = dtag_r;
  assign out_full_res    = full_r;
  assign out_count       = cnt_o_r;
  assign out_read_valid  = rvalid_r;
  assign out_read_time   = rtime_r;
  assign out_read_tag    = rtag_r;

`ifndef SYNTHESIS
  a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= eff_cap)
    else $error("stored count exceeds capacity");

  // A shift insert always has a newer time than the oldest entry, so one
  // cell in the row marks where it lands.
  a_one_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    ins_path |-> $onehot(bnd_v))
    else $error("insert boundary in the cell row is not unique");

  a_drop_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_accepted)
    else $error("entry dropped without an accepted insert");

  a_shift_stores: assert property (@(posedge clk) disable iff (!rst_n)
    ins_path |=> accepted_r && cnt_o_r != '0)
    else $error("shift insert did not store its entry");
`endif

endmodule

`default_nettype wire

>>> src/ntsb_cell.sv
// One slot of the sorted row: stored time and tag, local compare and
// shift/insert select. Depends on ntsb_pkg.
`default_nettype none

module ntsb_cell #(
  parameter int TAG_W = 16
) (
  input  wire                          clk,
  input  ntsb_pkg::cell_ctl_t          ctl,
  input  wire  [ntsb_pkg::TIME_W-1:0]  new_time,
  input  wire  [TAG_W-1:0]             new_tag,
  input  wire  [ntsb_pkg::TIME_W-1:0]  prev_time,
  input  wire  [TAG_W-1:0]             prev_tag,
  input  wire                          prev_lt,
  output logic [ntsb_pkg::TIME_W-1:0]  time_q,
  output logic [TAG_W-1:0]             tag_q,
  output ntsb_pkg::cell_flag_t         flags
);
  import ntsb_pkg::*;

  logic [TIME_W-1:0] time_r;
  logic [TAG_W-1:0]  tag_r;
  logic              take_new;
  logic              take_prev;

  always_comb begin
    flags.lt      = ctl.below_n && (new_time < time_r);
    flags.le_last = ctl.last && (new_time <= time_r);
    // The first cell whose entry is not newer than the request takes it;
    // every cell after that takes its neighbor's entry.
    take_new  = (ctl.ins && !flags.lt && prev_lt) || ctl.app_here;
    take_prev = ctl.ins && !flags.lt && !prev_lt;
  end

  always_ff @(posedge clk) begin
    if (take_new) begin
      time_r <= new_time;
      tag_r  <= new_tag;
    end else if (take_prev) begin
      time_r <= prev_time;
      tag_r  <= prev_tag;
    end
  end

  assign time_q = time_r;
  assign tag_q  = tag_r;

endmodule

`default_nettype wire

>>> tb/sv/ntsb_scoreboard_pkg.sv
// Scoreboard for the newest-first time-sorted buffer testbench.
// Holds its own sorted-store predictor and the queue of expected results.
// Depends on ntsb_pkg.
package ntsb_scoreboard_pkg;

  import ntsb_pkg::*;

  localparam int TAG_W = 16;
  localparam int SLOTS = 64;

  typedef logic [TIME_W-1:0] stamp_t;
  typedef logic [TAG_W-1:0]  tag_t;

  typedef struct packed {
    logic                accepted;
    logic [SLOT_W-1:0]   slot;
    logic                dropped;
    tag_t                dropped_tag;
    logic                full_res;
    logic [CNT_O_W-1:0]  count;
    logic                read_valid;
    stamp_t              read_time;
    tag_t                read_tag;
  } buf_result_t;

  class ntsb_scoreboard;
    stamp_t      entry_stamp[SLOTS];
    tag_t        entry_tag[SLOTS];
    int unsigned held;
    int unsigned cap_limit;
    buf_result_t pending_results[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      held = 0;
      cap_limit = SLOTS;
      mismatches = 0;
      results_seen = 0;
    endfunction

    // Out-of-range values are clamped, and a lower capacity silently cuts the
    // oldest entries.
    function void set_capacity(logic [CAP_W-1:0] value);
      if (value == 0) begin
        cap_limit = 1;
      end else if (value > SLOTS) begin
        cap_limit = SLOTS;
      end else begin
        cap_limit = value;
      end
      if (held > cap_limit) begin
        held = cap_limit;
      end
    endfunction

    function void note_request(func_t op, stamp_t stamp, tag_t tag,
                               logic [SLOT_W-1:0] idx);
      buf_result_t r;
      int unsigned n;
      int unsigned p;
      int unsigned i;
      r = '0;
      n = held;
      if (op == FUNC_INSERT) begin
        if (n > 0 && stamp <= entry_stamp[n-1]) begin
          if (n < cap_limit) begin
            entry_stamp[n] = stamp;
            entry_tag[n] = tag;
            r.accepted = 1'b1;
            r.slot = SLOT_W'(n);
            held = n + 1;
          end
        end else begin
          p = 0;
          while (p < n && stamp < entry_stamp[p]) p++;
          if (n >= cap_limit) begin
            r.dropped = 1'b1;
            r.dropped_tag = entry_tag[n-1];
            n = n - 1;
          end
          for (i = n; i > p; i--) begin
            entry_stamp[i] = entry_stamp[i-1];
            entry_tag[i] = entry_tag[i-1];
          end
          entry_stamp[p] = stamp;
          entry_tag[p] = tag;
          held = n + 1;
          r.accepted = 1'b1;
          r.slot = SLOT_W'(p);
        end
      end else if (idx < held) begin
        r.read_valid = 1'b1;
        r.read_time = entry_stamp[idx];
        r.read_tag = entry_tag[idx];
      end
      r.full_res = (held >= cap_limit);
      r.count = CNT_O_W'(held);
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at result %0d: %s", results_seen, what);
      mismatches++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
      end
    endtask

    task check_result(buf_result_t got);
      buf_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with no request outstanding, count %0d",
                                  got.count));
        return;
      end
      want = pending_results.pop_front();
      compare_field("accepted", got.accepted, want.accepted);
      compare_field("slot", got.slot, want.slot);
      compare_field("dropped", got.dropped, want.dropped);
      compare_field("dropped_tag", got.dropped_tag, want.dropped_tag);
      compare_field("full_res", got.full_res, want.full_res);
      compare_field("count", got.count, want.count);
      compare_field("read_valid", got.read_valid, want.read_valid);
      compare_field("read_time", got.read_time, want.read_time);
      compare_field("read_tag", got.read_tag, want.read_tag);
    endtask
  endclass

endpackage

>>> tb/sv/tb_top.sv
// Top of the testbench for the newest-first time-sorted buffer.
// Drives directed and random requests with random idling on both sides.
// Depends on ntsb_pkg, ntsb_scoreboard_pkg and newest_k_time_sorted_buffer_top.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import ntsb_pkg::*;
  import ntsb_scoreboard_pkg::*;

  localparam int     CYCLE_LIMIT = 400000;
  localparam int     PHASE_ITEMS = 285;
  localparam stamp_t STAMP_MAX   = '1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]  cfg_wr_data = CAP_RESET;
  logic              in_valid = 1'b0;
  logic              in_ready;
  func_t             in_func = FUNC_INSERT;
  stamp_t            in_timestamp = '0;
  tag_t              in_row_tag = '0;
  logic [SLOT_W-1:0] in_read_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_accepted;
  logic [SLOT_W-1:0] out_slot;
  logic              out_dropped;
  tag_t              out_dropped_tag;
  logic              out_full_res;
  logic [CNT_O_W-1:0] out_count;
  logic              out_read_valid;
  stamp_t            out_read_time;
  tag_t              out_read_tag;

  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_cycles = 0;
  int unsigned cycles = 0;

  ntsb_scoreboard sb = new();

  newest_k_time_sorted_buffer_top #(
    .DEPTH(SLOTS),
    .TAG_WIDTH(TAG_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_timestamp(in_timestamp),
    .in_row_tag(in_row_tag),
    .in_read_index(in_read_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_accepted(out_accepted),
    .out_slot(out_slot),
    .out_dropped(out_dropped),
    .out_dropped_tag(out_dropped_tag),
    .out_full_res(out_full_res),
    .out_count(out_count),
    .out_read_valid(out_read_valid),
    .out_read_time(out_read_time),
    .out_read_tag(out_read_tag)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Both handshakes are sampled at the edge, before any driver update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_request(in_func, in_timestamp, in_row_tag, in_read_index);
      end
      if (out_valid && out_ready) begin
        sb.check_result('{accepted: out_accepted, slot: out_slot,
                          dropped: out_dropped, dropped_tag: out_dropped_tag,
                          full_res: out_full_res, count: out_count,
                          read_valid: out_read_valid, read_time: out_read_time,
                          read_tag: out_read_tag});
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (rx_hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
        out_ready <= 1'b1;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_request(func_t op, stamp_t stamp, tag_t tag,
                              logic [SLOT_W-1:0] idx);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= op;
    in_timestamp <= stamp;
    in_row_tag <= tag;
    in_read_index <= idx;
    do @(posedge clk); while (!in_ready);
  endtask

  // A new capacity is to be written only once every result has drained; the block does not enforce it.
  task automatic write_capacity(logic [CAP_W-1:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.set_capacity(value);
    cfg_wr_en <= 1'b0;
  endtask

  // Times are biased toward ties, the append path and the extremes.
  function automatic stamp_t pick_stamp(int unsigned n);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      return stamp_t'($urandom_range(0, 40));
    end else if (sel < 50 && n > 0) begin
      return sb.entry_stamp[$urandom_range(0, n - 1)];
    end else if (sel < 65 && n > 0) begin
      return sb.entry_stamp[n - 1] - stamp_t'($urandom_range(0, 3));
    end else if (sel < 80) begin
      return stamp_t'({$urandom, $urandom});
    end else if (sel < 90) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return stamp_t'(1);
        2: return STAMP_MAX - 1;
        default: return STAMP_MAX;
      endcase
    end else if (n > 0) begin
      return sb.entry_stamp[0] + 1;
    end
    return stamp_t'({$urandom, $urandom});
  endfunction

  task automatic send_random_request();
    int unsigned n;
    logic [SLOT_W-1:0] idx;
    tag_t tag;
    n = sb.held;
    tag = tag_t'($urandom);
    if (n > 0 && $urandom_range(0, 4) != 0) begin
      idx = SLOT_W'($urandom_range(0, n));
    end else begin
      idx = SLOT_W'($urandom);
    end
    if ($urandom_range(0, 99) < 25) begin
      send_request(FUNC_READ, stamp_t'({$urandom, $urandom}), tag, idx);
    end else begin
      send_request(FUNC_INSERT, pick_stamp(n), tag, idx);
    end
  endtask

  initial begin
    int unsigned cap;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    tx_gap_pct = 20;
    rx_stall_pct = 20;

    // Empty buffer, ties, the append path and both time extremes.
    send_request(FUNC_READ, '0, '0, '0);
    send_request(FUNC_INSERT, '0, 16'h0000, '0);
    send_request(FUNC_INSERT, '0, 16'hFFFF, '1);
    send_request(FUNC_INSERT, STAMP_MAX, 16'h0001, '0);
    send_request(FUNC_INSERT, stamp_t'(5), 16'h0002, '0);
    send_request(FUNC_INSERT, stamp_t'(5), 16'h0003, '0);
    for (int i = 0; i < 6; i++) begin
      send_request(FUNC_READ, STAMP_MAX, '1, SLOT_W'(i));
    end
    send_request(FUNC_READ, '0, '0, '1);

    // Lowering the capacity below the stored count drops the oldest quietly.
    write_capacity(CAP_W'(3));
    send_request(FUNC_READ, '0, '0, SLOT_W'(2));
    send_request(FUNC_READ, '0, '0, SLOT_W'(3));
    send_request(FUNC_INSERT, '0, 16'h0004, '0);
    send_request(FUNC_INSERT, STAMP_MAX, 16'h0005, '0);
    write_capacity(CAP_W'(64));
    write_capacity(CAP_W'(1));
    send_request(FUNC_INSERT, stamp_t'(7), 16'h0006, '0);
    send_request(FUNC_INSERT, STAMP_MAX, 16'h0007, '0);
    send_request(FUNC_READ, '0, '0, SLOT_W'(0));
    send_request(FUNC_READ, '0, '0, SLOT_W'(1));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: cap = 64;
        1: cap = 1;
        2: cap = 2;
        3: cap = $urandom_range(3, 63);
        4: cap = $urandom_range(5, 20);
        default: cap = 64;
      endcase
      write_capacity(CAP_W'(cap));
      if (ph == 5) begin
        tx_gap_pct = 0;
        rx_stall_pct = 0;
      end else begin
        tx_gap_pct = (ph % 2 == 1) ? 35 : 12;
        rx_stall_pct = (ph % 2 == 1) ? 12 : 35;
      end
      // A long hold-off on the result side while requests keep coming.
      if (ph == 0) begin
        rx_hold_cycles = 300;
      end
      repeat (PHASE_ITEMS) send_random_request();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
